// ----- rtl/ascon_permutation_top_defines.svh -----
// ---------------------------------------------------------------------------
// Ascon permutation assertion macros
// Concurrent assertion wrappers shared by the permutation RTL.
// ---------------------------------------------------------------------------
`ifndef ASCON_PERMUTATION_TOP_DEFINES_SVH
`define ASCON_PERMUTATION_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Clocked assertion that is switched off while reset is asserted.
`define ASC_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASC_ASSERT(lbl, clk, rst_n, prop, msg)
`define ASC_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ----- rtl/ascon_pkg.sv -----
// ---------------------------------------------------------------------------
// Ascon permutation package
// Shared types, round constants and round-count codes.
// ---------------------------------------------------------------------------
package ascon_pkg;

	localparam int NUM_ROUNDS = 12;
	localparam int ROUND_W    = $clog2(NUM_ROUNDS);
	localparam int NUM_WORDS  = 5;

	// Round-count select codes.
	localparam logic [1:0] OP_P12 = 2'd0;
	localparam logic [1:0] OP_P8  = 2'd1;
	localparam logic [1:0] OP_P6  = 2'd2;

	// First round that an item of each kind actually runs.
	localparam logic [ROUND_W-1:0] START_P12 = ROUND_W'(0);
	localparam logic [ROUND_W-1:0] START_P8  = ROUND_W'(4);
	localparam logic [ROUND_W-1:0] START_P6  = ROUND_W'(6);

	typedef logic [63:0] word_t;
	typedef word_t [NUM_WORDS-1:0] state_t;

	typedef struct packed {
		logic [ROUND_W-1:0] start;
		state_t             state;
	} stage_data_t;

	function automatic logic [7:0] rc_of_round(input logic [ROUND_W-1:0] idx);
		logic [7:0] c;
		case (idx)
			ROUND_W'(0):  c = 8'hf0;
			ROUND_W'(1):  c = 8'he1;
			ROUND_W'(2):  c = 8'hd2;
			ROUND_W'(3):  c = 8'hc3;
			ROUND_W'(4):  c = 8'hb4;
			ROUND_W'(5):  c = 8'ha5;
			ROUND_W'(6):  c = 8'h96;
			ROUND_W'(7):  c = 8'h87;
			ROUND_W'(8):  c = 8'h78;
			ROUND_W'(9):  c = 8'h69;
			ROUND_W'(10): c = 8'h5a;
			ROUND_W'(11): c = 8'h4b;
			default:      c = 8'h00;
		endcase
		return c;
	endfunction

	// The unused select code runs the short permutation, like OP_P6.
	function automatic logic [ROUND_W-1:0] start_round(input logic [1:0] op);
		logic [ROUND_W-1:0] s;
		case (op)
			OP_P12:  s = START_P12;
			OP_P8:   s = START_P8;
			default: s = START_P6;
		endcase
		return s;
	endfunction

endpackage

// ----- rtl/ascon_if.sv -----
// ---------------------------------------------------------------------------
// Ascon permutation channels
// Valid/ready interfaces for the input state and the permuted state.
// ---------------------------------------------------------------------------
interface ascon_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [63:0] state_in0;
	logic [63:0] state_in1;
	logic [63:0] state_in2;
	logic [63:0] state_in3;
	logic [63:0] state_in4;

	modport source (
		output valid, op, state_in0, state_in1, state_in2, state_in3, state_in4,
		input  ready
	);
	modport sink (
		input  valid, op, state_in0, state_in1, state_in2, state_in3, state_in4,
		output ready
	);
endinterface

interface ascon_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] state_out0;
	logic [63:0] state_out1;
	logic [63:0] state_out2;
	logic [63:0] state_out3;
	logic [63:0] state_out4;

	modport source (
		output valid, state_out0, state_out1, state_out2, state_out3, state_out4,
		input  ready
	);
	modport sink (
		input  valid, state_out0, state_out1, state_out2, state_out3, state_out4,
		output ready
	);
endinterface

// ----- rtl/ascon_round.sv -----
// ---------------------------------------------------------------------------
// Ascon round
// One round: constant addition, bitsliced S-box and linear diffusion.
// ---------------------------------------------------------------------------
module perm_round (
	input  ascon_pkg::state_t st_in,
	input  logic [7:0]        rc,
	output ascon_pkg::state_t st_out
);
	import ascon_pkg::*;

	function automatic word_t ror(input word_t v, input int r);
		return (v >> r) | (v << (64 - r));
	endfunction

	word_t a0, a1, a2, a3, a4;
	word_t b0, b1, b2, b3, b4;
	word_t c0, c1, c2, c3, c4;

	always_comb begin
		// Constant addition and the input XOR layer of the S-box.
		a0 = st_in[0] ^ st_in[4];
		a4 = st_in[4] ^ st_in[3];
		a2 = st_in[2] ^ {56'd0, rc} ^ st_in[1];
		a1 = st_in[1];
		a3 = st_in[3];

		// Chi-like nonlinear core.
		b0 = a0 ^ (~a1 & a2);
		b1 = a1 ^ (~a2 & a3);
		b2 = a2 ^ (~a3 & a4);
		b3 = a3 ^ (~a4 & a0);
		b4 = a4 ^ (~a0 & a1);

		// Output XOR layer of the S-box.
		c1 = b1 ^ b0;
		c0 = b0 ^ b4;
		c3 = b3 ^ b2;
		c2 = ~b2;
		c4 = b4;

		st_out[0] = c0 ^ ror(c0, 19) ^ ror(c0, 28);
		st_out[1] = c1 ^ ror(c1, 61) ^ ror(c1, 39);
		st_out[2] = c2 ^ ror(c2, 1)  ^ ror(c2, 6);
		st_out[3] = c3 ^ ror(c3, 10) ^ ror(c3, 17);
		st_out[4] = c4 ^ ror(c4, 7)  ^ ror(c4, 41);
	end

endmodule

// ----- rtl/ascon_stage.sv -----
// ---------------------------------------------------------------------------
// Ascon pipeline stage
// One registered round with its own valid bit and ready back-pressure.
// ---------------------------------------------------------------------------
`include "ascon_permutation_top_defines.svh"

module ascon_stage (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [ascon_pkg::ROUND_W-1:0] round_idx,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ascon_pkg::stage_data_t      in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output ascon_pkg::stage_data_t      out_data
);
	import ascon_pkg::*;

	logic        valid_s;
	stage_data_t data_s;
	state_t      rnd_state;
	logic        active;
	logic        stall;

	perm_round u_round (
		.st_in  (in_data.state),
		.rc     (rc_of_round(round_idx)),
		.st_out (rnd_state)
	);

	// Items with fewer rounds skip the leading stages unchanged.
	assign active   = (round_idx >= in_data.start);
	assign in_ready = !valid_s || out_ready;
	assign stall    = valid_s && !out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (in_ready) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s.start <= in_data.start;
			data_s.state <= active ? rnd_state : in_data.state;
		end
	end

	assign out_valid = valid_s;
	assign out_data  = data_s;

	`ASC_ASSERT(a_load, clk, arst_n, in_valid && in_ready |=> valid_s, "stage dropped a transfer")
	`ASC_ASSERT(a_hold, clk, arst_n, stall |=> valid_s && $stable(data_s), "stalled stage changed")
	`ASC_ASSERT(a_drain, clk, arst_n, !in_valid && out_ready |=> !valid_s, "stage repeated")

endmodule

// ----- rtl/ascon_permutation_top.sv -----
// ---------------------------------------------------------------------------
// Ascon permutation top level
// Twelve-stage pipelined Ascon p12 / p8 / p6 permutation on valid/ready.
// ---------------------------------------------------------------------------
// The block applies the Ascon permutation to a 320-bit state given as five
// 64-bit words. The op field selects 12 rounds (op = 0), 8 rounds (op = 1)
// or 6 rounds (op = 2; the unused code 3 also gives 6 rounds). The datapath
// is a chain of twelve register stages, one round each, and every item
// goes through all twelve of them whatever its round count: shorter
// permutations pass through the leading stages untouched and use the tail
// of the round-constant table. A new item can be taken in every cycle
// unless a stalled output has backed the pipeline up to its input, so the
// sustained rate is one transfer per cycle and up to twelve items are in
// flight at once. Each stage has its own valid bit and advances whenever
// the stage after it is empty or moving, so a stalled output fills the
// pipeline from the back and empty slots are squeezed out. The last stage
// is the output register. There is no configuration and no state between
// items.
`include "ascon_permutation_top_defines.svh"

module ascon_permutation_top (
	input logic        clk,
	input logic        arst_n,
	ascon_in_if.sink   in_ch,
	ascon_out_if.source out_ch
);
	import ascon_pkg::*;

	// Index 0 is the input side; index k is the output of stage k.
	logic        vld [NUM_ROUNDS+1];
	logic        rdy [NUM_ROUNDS+1];
	stage_data_t dat [NUM_ROUNDS+1];
	logic        start_ok;
	logic        out_stall;

	assign vld[0]         = in_ch.valid;
	assign in_ch.ready    = rdy[0];
	assign dat[0].start   = start_round(in_ch.op);
	assign dat[0].state[0] = in_ch.state_in0;
	assign dat[0].state[1] = in_ch.state_in1;
	assign dat[0].state[2] = in_ch.state_in2;
	assign dat[0].state[3] = in_ch.state_in3;
	assign dat[0].state[4] = in_ch.state_in4;

	genvar i;
	generate
		for (i = 0; i < NUM_ROUNDS; i++) begin : g_stage
			ascon_stage u_stage (
				.clk       (clk),
				.arst_n    (arst_n),
				.round_idx (ROUND_W'(i)),
				.in_valid  (vld[i]),
				.in_ready  (rdy[i]),
				.in_data   (dat[i]),
				.out_valid (vld[i+1]),
				.out_ready (rdy[i+1]),
				.out_data  (dat[i+1])
			);
		end
	endgenerate

	assign rdy[NUM_ROUNDS]  = out_ch.ready;
	assign out_ch.valid     = vld[NUM_ROUNDS];
	assign out_ch.state_out0 = dat[NUM_ROUNDS].state[0];
	assign out_ch.state_out1 = dat[NUM_ROUNDS].state[1];
	assign out_ch.state_out2 = dat[NUM_ROUNDS].state[2];
	assign out_ch.state_out3 = dat[NUM_ROUNDS].state[3];
	assign out_ch.state_out4 = dat[NUM_ROUNDS].state[4];

	assign start_ok  = (dat[NUM_ROUNDS].start == START_P12) ||
	                   (dat[NUM_ROUNDS].start == START_P8) ||
	                   (dat[NUM_ROUNDS].start == START_P6);
	assign out_stall = out_ch.valid && !out_ch.ready;

	// Only the three legal start rounds may reach the output.
	`ASC_ASSERT(a_start_legal, clk, arst_n, vld[NUM_ROUNDS] |-> start_ok, "illegal start round")
	// The last stage can never be blocked while the output stage is free.
	`ASC_ASSERT_ALWAYS(a_in_ready, clk, !vld[NUM_ROUNDS] |-> rdy[NUM_ROUNDS-1], "last stage blocked")
	// A result that waits on the output stays offered, with word 0 unchanged.
	`ASC_ASSERT(a_out_hold, clk, arst_n, out_stall |=> out_ch.valid && $stable(out_ch.state_out0), "result changed")

endmodule

// ----- tb/sv/testbench.sv -----
// ---------------------------------------------------------------------------
// Ascon permutation testbench
// Drives 320-bit states with p12 / p8 / p6 round selects through the
// valid/ready input channel and checks every permuted state word against
// a behavioral model of the Ascon rounds, under several idling patterns.
// ---------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ascon_pkg::*;

	// The one select code the package leaves unnamed; it must behave like p6.
	localparam logic [1:0] OP_SPARE = 2'd3;

	// Round constants, indexed by absolute round number; shorter
	// permutations start part way into the table.
	localparam logic [7:0] ROUND_CONSTS [12] = '{
		8'hf0, 8'he1, 8'hd2, 8'hc3, 8'hb4, 8'ha5,
		8'h96, 8'h87, 8'h78, 8'h69, 8'h5a, 8'h4b
	};

	// Every transfer passes through twelve register stages, so a generous
	// tail after the last result covers anything still in flight.
	localparam int PIPE_DEPTH   = 12;
	localparam int TAIL_CYCLES  = 4 * PIPE_DEPTH;
	localparam int STALL_LIMIT  = 4000;
	localparam int REPORT_LIMIT = 10;
	localparam int SEGMENT_LEN  = 125;

	// Handshake pressure modes. The sender idles in SEND_IDLE_PCT percent
	// of its free cycles, the receiver drops ready in RECV_STALL_PCT.
	typedef enum logic [1:0] {
		MODE_FREE,
		MODE_SRC_IDLE,
		MODE_SNK_STALL,
		MODE_BOTH
	} traffic_mode_e;

	localparam int SEND_IDLE_PCT  [4] = '{0, 84, 0, 10};
	localparam int RECV_STALL_PCT [4] = '{0, 0, 84, 10};

	typedef struct {
		logic [1:0]    op;
		state_t        words;
		traffic_mode_e mode;
		bit            drain_first;  // hold until the pipeline is empty
	} perm_block_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	ascon_in_if  in_if ();
	ascon_out_if out_if ();

	ascon_permutation_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_if),
		.out_ch (out_if)
	);

	perm_block_t   pending_blocks [$];
	state_t        predicted_states [$];
	traffic_mode_e traffic_mode = MODE_FREE;

	int error_count = 0;
	int results_checked = 0;
	int op_counts [4] = '{0, 0, 0, 0};
	int quiet_cycles = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// -----------------------------------------------------------------------
	// Behavioral model of the permutation
	// -----------------------------------------------------------------------

	function automatic word_t rotr(input word_t v, input int unsigned r);
		return (v >> r) | (v << (64 - r));
	endfunction

	function automatic state_t make_state(input word_t w0, input word_t w1,
			input word_t w2, input word_t w3, input word_t w4);
		state_t s;
		s[0] = w0;
		s[1] = w1;
		s[2] = w2;
		s[3] = w3;
		s[4] = w4;
		return s;
	endfunction

	function automatic state_t permute_state(input logic [1:0] op, input state_t s);
		int first;
		word_t x0, x1, x2, x3, x4;
		word_t t0, t1, t2, t3, t4;
		case (op)
			OP_P12:  first = 0;
			OP_P8:   first = 4;
			default: first = 6;  // p6, and the spare code maps here too
		endcase
		x0 = s[0];
		x1 = s[1];
		x2 = s[2];
		x3 = s[3];
		x4 = s[4];
		for (int r = first; r < 12; r++) begin
			x2 ^= word_t'(ROUND_CONSTS[r]);

			// Five-bit S-box applied to every bit column at once.
			x0 ^= x4;
			x4 ^= x3;
			x2 ^= x1;
			t0 = ~x0 & x1;
			t1 = ~x1 & x2;
			t2 = ~x2 & x3;
			t3 = ~x3 & x4;
			t4 = ~x4 & x0;
			x0 ^= t1;
			x1 ^= t2;
			x2 ^= t3;
			x3 ^= t4;
			x4 ^= t0;
			x1 ^= x0;
			x0 ^= x4;
			x3 ^= x2;
			x2 = ~x2;

			// Linear layer: each word mixed with two rotations of itself.
			x0 = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
			x1 = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
			x2 = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
			x3 = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
			x4 = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
		end
		return make_state(x0, x1, x2, x3, x4);
	endfunction

	// -----------------------------------------------------------------------
	// Stimulus construction
	// -----------------------------------------------------------------------

	task automatic queue_block(input logic [1:0] op, input state_t s,
			input traffic_mode_e mode, input bit drain_first);
		perm_block_t b;
		b.op          = op;
		b.words       = s;
		b.mode        = mode;
		b.drain_first = drain_first;
		pending_blocks.push_back(b);
	endtask

	// Mostly dense random words; now and then an all-zero or all-one word so
	// that the S-box sees degenerate columns inside otherwise random states.
	function automatic word_t pick_word();
		int unsigned roll;
		roll = $urandom_range(19);
		if (roll == 0)
			return '0;
		else if (roll == 1)
			return '1;
		else
			return {$urandom, $urandom};
	endfunction

	// -----------------------------------------------------------------------
	// Input driver: presents the head of the pending queue, holds it until the
	// transfer completes, and predicts the result at the transfer edge.
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_if.valid     <= 1'b0;
			in_if.op        <= OP_P12;
			in_if.state_in0 <= '0;
			in_if.state_in1 <= '0;
			in_if.state_in2 <= '0;
			in_if.state_in3 <= '0;
			in_if.state_in4 <= '0;
		end else begin
			if (in_if.valid && in_if.ready) begin
				predicted_states.push_back(permute_state(pending_blocks[0].op,
					pending_blocks[0].words));
				op_counts[pending_blocks[0].op]++;
				pending_blocks.pop_front();
			end
			// A held item stays on the bus; otherwise pick what comes next.
			if (!in_if.valid || in_if.ready) begin
				if (pending_blocks.size() == 0) begin
					in_if.valid <= 1'b0;
				end else if (pending_blocks[0].drain_first && predicted_states.size() != 0) begin
					// Let the pipeline run dry before this segment starts.
					in_if.valid  <= 1'b0;
					traffic_mode <= pending_blocks[0].mode;
				end else if ($urandom_range(99) < SEND_IDLE_PCT[pending_blocks[0].mode]) begin
					in_if.valid  <= 1'b0;
					traffic_mode <= pending_blocks[0].mode;
				end else begin
					in_if.valid     <= 1'b1;
					in_if.op        <= pending_blocks[0].op;
					in_if.state_in0 <= pending_blocks[0].words[0];
					in_if.state_in1 <= pending_blocks[0].words[1];
					in_if.state_in2 <= pending_blocks[0].words[2];
					in_if.state_in3 <= pending_blocks[0].words[3];
					in_if.state_in4 <= pending_blocks[0].words[4];
					traffic_mode    <= pending_blocks[0].mode;
				end
			end
		end
	end

	// -----------------------------------------------------------------------
	// Output monitor: compares every result transfer, word by word, with the
	// oldest prediction, and throttles ready according to the current mode.
	// -----------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		state_t got;
		state_t want;
		if (!arst_n) begin
			out_if.ready <= 1'b0;
		end else begin
			if (out_if.valid && out_if.ready) begin
				got = make_state(out_if.state_out0, out_if.state_out1,
					out_if.state_out2, out_if.state_out3, out_if.state_out4);
				if (predicted_states.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT)
						$display("%t: result transfer with no prediction pending: %h",
							$realtime, got);
				end else begin
					want = predicted_states.pop_front();
					results_checked++;
					for (int k = 0; k < NUM_WORDS; k++) begin
						if (got[k] !== want[k]) begin
							error_count++;
							if (error_count <= REPORT_LIMIT)
								$display("%t: state_out%0d mismatch: expected %h, got %h",
									$realtime, k, want[k], got[k]);
						end
					end
				end
			end
			out_if.ready <= ($urandom_range(99) >= RECV_STALL_PCT[traffic_mode]);
		end
	end

	// Watchdog: any transfer on either channel counts as progress.
	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("%t: no transfer for %0d cycles, %0d items unsent, %0d results due",
				$realtime, STALL_LIMIT, pending_blocks.size(), predicted_states.size());
			$display("ascon_permutation_top verification failed");
			$finish;
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence: directed corners, then random segments that rotate
	// through the handshake modes, then drain and report.
	// -----------------------------------------------------------------------
	initial begin
		logic [1:0] sel_codes [4];
		traffic_mode_e seg_modes [4];
		word_t alt_a;
		word_t alt_b;
		int total_items;

		sel_codes = '{OP_P12, OP_P8, OP_P6, OP_SPARE};
		seg_modes = '{MODE_FREE, MODE_SRC_IDLE, MODE_SNK_STALL, MODE_BOTH};
		alt_a = 64'h5555_5555_5555_5555;
		alt_b = 64'haaaa_aaaa_aaaa_aaaa;

		// Known values on every input from time zero.
		in_if.valid     = 1'b0;
		in_if.op        = OP_P12;
		in_if.state_in0 = '0;
		in_if.state_in1 = '0;
		in_if.state_in2 = '0;
		in_if.state_in3 = '0;
		in_if.state_in4 = '0;
		out_if.ready    = 1'b0;

		// Directed corners: all-zero and all-one states under every select
		// code, including the spare code that must fall back to six rounds.
		foreach (sel_codes[i]) begin
			queue_block(sel_codes[i], make_state('0, '0, '0, '0, '0), MODE_FREE, 1'b0);
			queue_block(sel_codes[i], make_state('1, '1, '1, '1, '1), MODE_FREE, 1'b0);
		end
		// Alternating bit patterns, so neighboring columns differ.
		queue_block(OP_P12, make_state(alt_a, alt_b, alt_a, alt_b, alt_a), MODE_FREE, 1'b0);
		queue_block(OP_P8, make_state(alt_b, alt_a, alt_b, alt_a, alt_b), MODE_FREE, 1'b0);
		// Words holding a lone top bit or a lone bottom bit exercise the
		// rotation wrap-around.
		queue_block(OP_P6, make_state(64'h8000_0000_0000_0000, 64'h1,
			64'h8000_0000_0000_0000, 64'h1, 64'h8000_0000_0000_0000), MODE_FREE, 1'b0);
		queue_block(OP_SPARE, make_state(64'h1, 64'h8000_0000_0000_0000, 64'h1,
			64'h8000_0000_0000_0000, 64'h1), MODE_FREE, 1'b0);
		// An initialization-style state: IV word, then key and nonce words.
		queue_block(OP_P12, make_state(64'h8040_0c06_0000_0000,
			64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f,
			64'h0001_0203_0405_0607, 64'h0809_0a0b_0c0d_0e0f), MODE_FREE, 1'b0);
		// Only word 2 set, where the round constant lands.
		queue_block(OP_P8, make_state('0, '0, 64'hffff_ffff_ffff_ff00, '0, '0),
			MODE_FREE, 1'b0);

		// Random part: two passes over the four modes. The first item of each
		// segment waits for the pipeline to empty, which also gives a clean
		// boundary between modes.
		for (int seg = 0; seg < 8; seg++) begin
			for (int n = 0; n < SEGMENT_LEN; n++) begin
				queue_block(2'($urandom_range(3)),
					make_state(pick_word(), pick_word(), pick_word(), pick_word(), pick_word()),
					seg_modes[seg % 4], n == 0);
			end
		end
		total_items = pending_blocks.size();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_blocks.size() != 0 || predicted_states.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Ran %0d permutations through all four handshake modes: %0d p12, %0d p8,",
			total_items, op_counts[OP_P12], op_counts[OP_P8]);
		$display("%0d p6 and %0d with the spare select code; %0d results checked, %0d errors.",
			op_counts[OP_P6], op_counts[OP_SPARE], results_checked, error_count);

		if (error_count == 0 && predicted_states.size() == 0) begin
			$display("ascon_permutation_top verification clean");
		end else begin
			$display("ascon_permutation_top verification failed");
		end
		$finish;
	end

endmodule
